>>> rtl/core/bia_pkg.sv
// Shared types and constants for the bitmap ID allocator.
// Holds the operation codes, the result record and the fixed field widths.
// No dependencies.
`timescale 1ns / 1ps

package bia_pkg;

   // Width of an identifier as carried on the item channels.
   localparam int ID_W = 15;

   // Width of the operation selector.
   localparam int MODE_W = 2;

   // Operation codes; the fourth code has no meaning and is rejected.
   typedef enum logic [MODE_W-1:0] {
      MODE_ALLOC = 2'd0,
      MODE_MARK  = 2'd1,
      MODE_FREE  = 2'd2
   } mode_type;

   // One result item as handed from the sequencer to the output register.
   typedef struct packed {
      logic [ID_W-1:0] granted_ident;
      logic            success;
   } result_type;

endpackage

>>> rtl/core/bitmap_id_allocator_with_rover.sv
// Top level of the next-fit bitmap ID allocator.
// Depends on bia_pkg, bia_ram and bia_ctrl.
//
// Usage:
//  - The request channel (req_*) carries one operation per item: allocate,
//    mark an ID as used, or free an ID. The operation code travels in
//    req_tuser, the ID in req_tdata.
//  - The response channel (rsp_*) returns exactly one item per request with
//    the granted ID and a success flag.
//  - Mark and free split the ID into word index and bit by a reciprocal
//    multiplication, then do a read-modify-write of one bitmap word. Mark or
//    free of ID zero or of an out-of-range ID, and an unknown code, answer without touching the bitmap.
//  - Allocate grants from the rover word when it has a free bit, and otherwise
//    scans the bitmap from word zero with one read of the bitmap memory per cycle.
//  - One item is in work at a time; the next item is accepted while the
//    previous result still waits in the output register.
//  - After reset the bitmap is cleared by a pass over all NUM_WORDS words,
//    one word a cycle, during which req_tready stays low. The rover returns to
//    word zero.
//  - When the receiver stalls, the result holds in the output register and
//    the sequencer waits at its end until that register is free.
`timescale 1ns / 1ps

module bitmap_id_allocator_with_rover #(
   parameter int NUM_WORDS = 1024,
   parameter int WORD_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [14:0] ident, [15] zero
   input  logic [1:0]  req_tuser,  // [1:0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // [14:0] granted_ident, [15] success
);

   import bia_pkg::*;

   localparam int ADDR_W = $clog2(NUM_WORDS);

   logic                 mem_wr_en;
   logic [ADDR_W-1:0]    mem_wr_addr;
   logic [WORD_BITS-1:0] mem_wr_data;
   logic                 mem_rd_en;
   logic [ADDR_W-1:0]    mem_rd_addr;
   logic [WORD_BITS-1:0] mem_rd_data;

   logic       res_valid;
   logic       res_ready;
   result_type res;

   logic       rsp_valid_ff;
   result_type rsp_ff;

   bia_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (NUM_WORDS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   bia_ctrl #(
      .NUM_WORDS (NUM_WORDS),
      .WORD_BITS (WORD_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_mode     (req_tuser),
      .in_ident    (req_tdata[ID_W-1:0]),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // Output register: takes a result whenever it is empty or being drained.
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
      if (res_ready && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.success, rsp_ff.granted_ident};

endmodule

>>> rtl/core/bia_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the used-ID bitmap; no package dependencies.
`timescale 1ns / 1ps

module bia_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/bia_ctrl.sv
// Sequencer of the bitmap ID allocator: clearing pass, allocate scan,
// mark and free read-modify-write and the word index split.
// Depends on bia_pkg; drives the ports of one bia_ram instance.
`timescale 1ns / 1ps

module bia_ctrl #(
   parameter int NUM_WORDS = 1024,
   parameter int WORD_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   // Input item handshake
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [bia_pkg::MODE_W-1:0]   in_mode,
   input  logic [bia_pkg::ID_W-1:0]     in_ident,
   // Result towards the output register
   output logic                         res_valid,
   input  logic                         res_ready,
   output bia_pkg::result_type          res,
   // Bitmap memory
   output logic                         mem_wr_en,
   output logic [$clog2(NUM_WORDS)-1:0] mem_wr_addr,
   output logic [WORD_BITS-1:0]         mem_wr_data,
   output logic                         mem_rd_en,
   output logic [$clog2(NUM_WORDS)-1:0] mem_rd_addr,
   input  logic [WORD_BITS-1:0]         mem_rd_data
);

   import bia_pkg::*;

   localparam int ADDR_W  = $clog2(NUM_WORDS);
   localparam int BIT_W   = $clog2(WORD_BITS);
   localparam int DIV_SH  = ID_W + BIT_W;
   localparam int RECIP_W = ID_W + 2;
   localparam int PROD_W  = ID_W + RECIP_W;
   localparam logic [ADDR_W-1:0]  LAST_WORD = ADDR_W'(NUM_WORDS - 1);
   localparam logic [ADDR_W:0]    WORDS_EXT = (ADDR_W + 1)'(NUM_WORDS);
   localparam logic [31:0]        ID_LIMIT  = 32'(NUM_WORDS * WORD_BITS);
   localparam logic [RECIP_W-1:0] RECIP     =
      RECIP_W'(((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_RD0,
      S_WR0,
      S_RDR,
      S_CHKR,
      S_SCAN,
      S_DIV,
      S_MRD,
      S_MWR,
      S_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [ADDR_W-1:0] rover_ff, rover_in;
   logic [ADDR_W-1:0] chk_addr_ff, chk_addr_in;
   logic [ADDR_W-1:0] scan_addr_ff, scan_addr_in;
   logic              pend_ff, pend_in;
   logic              is_mark_ff, is_mark_in;
   logic [ID_W-1:0]   dvd_ff, dvd_in;
   logic [BIT_W-1:0]  rem_ff, rem_in;
   result_type        res_ff, res_in;

   // Lowest free bit of the word just read, and the ID it stands for.
   logic [WORD_BITS-1:0] free_onehot;
   logic                 word_full;
   logic [BIT_W-1:0]     free_bit;
   logic [31:0]          grant_sum;

   always_comb begin
      free_onehot = ~mem_rd_data & (mem_rd_data + WORD_BITS'(1));
      word_full   = &mem_rd_data;
      free_bit    = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         if (free_onehot[b]) begin
            free_bit = free_bit | BIT_W'(b);
         end
      end
      grant_sum = 32'(chk_addr_ff) * 32'(WORD_BITS) + 32'(free_bit);
   end

   // Word index and bit of the ident, by multiplication with the reciprocal
   // of the word width; the bit is what is left after taking the word back off.
   logic [PROD_W-1:0] div_prod;
   logic [ID_W-1:0]   div_quot;
   logic [ID_W-1:0]   div_back;
   logic [BIT_W-1:0]  div_rem;

   always_comb begin
      div_prod = PROD_W'(dvd_ff) * PROD_W'(RECIP);
      div_quot = ID_W'(div_prod >> DIV_SH);
      div_back = ID_W'(32'(div_quot) * 32'(WORD_BITS));
      div_rem  = BIT_W'(dvd_ff - div_back);
   end

   // Range test for mark and free.
   logic ident_ok;
   assign ident_ok = (in_ident != '0) && ({17'b0, in_ident} < ID_LIMIT);

   // Bit mask of the ident within its word.
   logic [WORD_BITS-1:0] ident_mask;
   assign ident_mask = WORD_BITS'(1) << rem_ff;

   // Next state and memory control.
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      rover_in     = rover_ff;
      chk_addr_in  = chk_addr_ff;
      scan_addr_in = scan_addr_ff;
      pend_in      = pend_ff;
      is_mark_in   = is_mark_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      res_in       = res_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = '0;
      mem_wr_data  = '0;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = '0;

      unique case (state_ff)
         S_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_addr_ff;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == LAST_WORD) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (in_valid) begin
               res_in.granted_ident = '0;
               res_in.success       = 1'b1;
               is_mark_in           = (in_mode == MODE_MARK);
               dvd_in               = in_ident;
               rem_in               = '0;
               case (in_mode)
                  MODE_ALLOC: begin
                     state_in = S_RD0;
                  end
                  MODE_MARK, MODE_FREE: begin
                     state_in = ident_ok ? S_DIV : S_DONE;
                  end
                  default: begin
                     res_in.success = 1'b0;
                     state_in       = S_DONE;
                  end
               endcase
            end
         end
         S_RD0: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = '0;
            state_in    = S_WR0;
         end
         S_WR0: begin
            // ID zero is always held as used.
            mem_wr_en   = 1'b1;
            mem_wr_addr = '0;
            mem_wr_data = mem_rd_data | WORD_BITS'(1);
            state_in    = S_RDR;
         end
         S_RDR: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = rover_ff;
            chk_addr_in = rover_ff;
            state_in    = S_CHKR;
         end
         S_CHKR: begin
            if (({1'b0, rover_ff} < WORDS_EXT) && !word_full) begin
               mem_wr_en            = 1'b1;
               mem_wr_addr          = chk_addr_ff;
               mem_wr_data          = mem_rd_data | free_onehot;
               res_in.granted_ident = grant_sum[ID_W-1:0];
               state_in             = S_DONE;
            end else begin
               scan_addr_in = '0;
               pend_in      = 1'b0;
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            // One read issued per cycle; the word read last cycle is checked.
            if (pend_ff && !word_full) begin
               mem_wr_en            = 1'b1;
               mem_wr_addr          = chk_addr_ff;
               mem_wr_data          = mem_rd_data | free_onehot;
               res_in.granted_ident = grant_sum[ID_W-1:0];
               rover_in             = chk_addr_ff;
               state_in             = S_DONE;
            end else if (pend_ff && (chk_addr_ff == LAST_WORD)) begin
               res_in.success = 1'b0;
               state_in       = S_DONE;
            end else begin
               mem_rd_en    = 1'b1;
               mem_rd_addr  = scan_addr_ff;
               chk_addr_in  = scan_addr_ff;
               pend_in      = 1'b1;
               scan_addr_in = scan_addr_ff + ADDR_W'(1);
            end
         end
         S_DIV: begin
            dvd_in   = div_quot;
            rem_in   = div_rem;
            state_in = S_MRD;
         end
         S_MRD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = dvd_ff[ADDR_W-1:0];
            state_in    = S_MWR;
         end
         S_MWR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = dvd_ff[ADDR_W-1:0];
            mem_wr_data = is_mark_ff ? (mem_rd_data | ident_mask)
                                     : (mem_rd_data & ~ident_mask);
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered values.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_addr_ff <= '0;
         rover_ff    <= '0;
         pend_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         rover_ff    <= rover_in;
         pend_ff     <= pend_in;
      end
      chk_addr_ff  <= chk_addr_in;
      scan_addr_ff <= scan_addr_in;
      is_mark_ff   <= is_mark_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      res_ff       <= res_in;
   end

   assign in_ready  = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res       = res_ff;

endmodule

>>> rtl/core/bia_checker.sv
// Port-level checker for the bitmap ID allocator, bound to its top level.
// Depends on nothing but the ports of bitmap_id_allocator_with_rover.
`timescale 1ns / 1ps

module bia_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // Items accepted whose results have not yet been taken.
   logic [1:0] pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_ff + 2'(req_tvalid && req_tready)
                            - 2'(rsp_tvalid && rsp_tready);
      end
   end

   // No result is offered in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered straight after reset");

   // A stalled result holds its value.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Every result answers an accepted item.
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pend_ff != 2'd0)
      else $error("result without an accepted item");

   // At most one item in work and one waiting result.
   a_bounded: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("more items outstanding than the block can hold");

   // A failed operation hands out no ID.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[15] |-> rsp_tdata[14:0] == 15'd0)
      else $error("failed result carries an ID");

endmodule

bind bitmap_id_allocator_with_rover bia_checker u_bia_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
